/* hw/rtl/ptl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptl_pkg: shared types and constants for the positional list table
// Command codes, sequencer states and the cell control struct.
// ----------------------------------------------------------------------------
package ptl_pkg;

  localparam int CAPACITY_DEF     = 64;
  localparam int PAYLOAD_BITS_DEF = 64;

  localparam int CMD_W = 3;
  localparam int POS_W = 7;
  localparam int KEY_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND     = 3'd0,
    CMD_INSERT     = 3'd1,
    CMD_REMOVE_END = 3'd2,
    CMD_REMOVE_AT  = 3'd3,
    CMD_FIND       = 3'd4,
    CMD_READ       = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DONE
  } state_e;

  // Broadcast to every cell; each cell compares the index against its own
  typedef struct packed {
    logic load;   // write the new record at the index
    logic open;   // cells above the index take their lower neighbor
    logic close;  // cells at and above the index take their upper neighbor
  } ptl_ctl_t;

endpackage

/* hw/rtl/ptl_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptl_cell: one slot of the positional list
// Holds one record, shifts it to or from its neighbors and compares its key.
// ----------------------------------------------------------------------------
module ptl_cell
  import ptl_pkg::*;
#(
  parameter int IDX_W = 6,
  parameter int CNT_W = 7,
  parameter int IDX   = 0,
  parameter int PAY_W = 64
) (
  input  logic                    clk_i,
  input  ptl_ctl_t                ctl_i,
  input  logic [IDX_W-1:0]        idx_i,
  input  logic [CNT_W-1:0]        cnt_i,
  input  logic signed [KEY_W-1:0] key_i,
  input  logic [PAY_W-1:0]        pay_i,
  input  logic signed [KEY_W-1:0] left_key_i,
  input  logic [PAY_W-1:0]        left_pay_i,
  input  logic signed [KEY_W-1:0] right_key_i,
  input  logic [PAY_W-1:0]        right_pay_i,
  output logic signed [KEY_W-1:0] key_o,
  output logic [PAY_W-1:0]        pay_o,
  output logic                    match_o
);

  logic signed [KEY_W-1:0] key_q, key_d;
  logic [PAY_W-1:0]        pay_q, pay_d;
  logic                    here, above, at_or_above;

  // Locate this slot relative to the broadcast index
  always_comb begin
    here        = (idx_i == IDX_W'(IDX));
    above       = (IDX_W'(IDX) > idx_i);
    at_or_above = (IDX_W'(IDX) >= idx_i);
  end

  // Pick the next record: load, shift up, shift down or hold
  always_comb begin
    key_d = key_q;
    pay_d = pay_q;
    if (ctl_i.load && here) begin
      key_d = key_i;
      pay_d = pay_i;
    end else if (ctl_i.open && above) begin
      key_d = left_key_i;
      pay_d = left_pay_i;
    end else if (ctl_i.close && at_or_above) begin
      key_d = right_key_i;
      pay_d = right_pay_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pay_q <= pay_d;
  end

  // Match only on live slots below the fill count
  assign match_o = (key_q == key_i) && (CNT_W'(IDX) < cnt_i);
  assign key_o   = key_q;
  assign pay_o   = pay_q;

endmodule

/* hw/rtl/positional_list_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_table: ordered list of keyed records in a row of cells
// Sequence: an accepted command goes to ST_EVAL, then to ST_DONE, where the
//   result strobe done_o is high; the receiver cannot stall it.
// A new command is refused while busy in ST_EVAL and taken in ST_DONE. The
//   cells evaluate and shift in ST_EVAL; the match encoder settles in ST_DONE.
// Reset: the fill count clears (list empty); record storage is not cleared.
// ----------------------------------------------------------------------------
module positional_list_table
  import ptl_pkg::*;
#(
  parameter int CAPACITY     = CAPACITY_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [CMD_W-1:0]        cmd_i,
  input  logic [POS_W-1:0]        position_i,
  input  logic signed [KEY_W-1:0] item_key_i,
  input  logic [PAYLOAD_BITS-1:0] item_payload_i,
  output logic                    done_o,
  output logic                    ok_o,
  output logic [POS_W-1:0]        found_position_o,
  output logic signed [KEY_W-1:0] out_key_o,
  output logic [PAYLOAD_BITS-1:0] out_payload_o,
  output logic [POS_W-1:0]        entry_count_o
);

  localparam int IW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  state_e state_q, state_d;

  logic [CMD_W-1:0]        cmd_q;
  logic [POS_W-1:0]        pos_q;
  logic signed [KEY_W-1:0] key_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic [CW-1:0]           count_q, count_d;
  logic                    ok_q, ok_d;
  logic [CAPACITY-1:0]     match_q, match_w;
  logic signed [KEY_W-1:0] rd_key_q, rd_key_d;
  logic [PAYLOAD_BITS-1:0] rd_pay_q, rd_pay_d;

  logic                    accept;
  logic                    in_eval;
  logic                    rd_en;
  logic [IW-1:0]           idx;
  logic [IW-1:0]           rd_idx;
  ptl_ctl_t                ctl;
  logic [CMPW-1:0]         pos_x, cnt_x, cap_x;
  logic                    not_full, pos_ins_ok, pos_ok;
  logic [IW-1:0]           hit_idx;
  logic                    any_hit;

  logic signed [KEY_W-1:0] cell_key [CAPACITY];
  logic [PAYLOAD_BITS-1:0] cell_pay [CAPACITY];

  assign accept  = start && !busy;
  assign in_eval = (state_q == ST_EVAL);

  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start) state_d = ST_EVAL;
      ST_EVAL: state_d = ST_DONE;
      ST_DONE: state_d = start ? ST_EVAL : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    busy   = 1'b0;
    done_o = 1'b0;
    case (state_q)
      ST_EVAL: busy   = 1'b1;
      ST_DONE: done_o = 1'b1;
      default: begin
        busy   = 1'b0;
        done_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
      pos_q <= position_i;
      key_q <= item_key_i;
      pay_q <= item_payload_i;
    end
  end

  // Range checks in a common width
  always_comb begin
    pos_x      = CMPW'(pos_q);
    cnt_x      = CMPW'(count_q);
    cap_x      = CMPW'(CAPACITY);
    not_full   = (cnt_x < cap_x);
    pos_ins_ok = (pos_x != '0) && (pos_x <= cnt_x + CMPW'(1));
    pos_ok     = (pos_x != '0) && (pos_x <= cnt_x);
  end

  // Decode the command into cell control, read select and count update
  always_comb begin
    ok_d    = 1'b0;
    ctl     = '0;
    rd_en   = 1'b0;
    count_d = count_q;
    idx     = IW'(pos_x - CMPW'(1));
    rd_idx  = IW'(pos_x - CMPW'(1));
    case (cmd_q)
      CMD_APPEND: begin
        ok_d     = not_full;
        idx      = IW'(count_q);
        ctl.load = not_full;
      end
      CMD_INSERT: begin
        ok_d     = not_full && pos_ins_ok;
        ctl.load = ok_d;
        ctl.open = ok_d;
      end
      CMD_REMOVE_END: begin
        ok_d   = (count_q != '0);
        rd_idx = IW'(count_q - CW'(1));
        rd_en  = ok_d;
      end
      CMD_REMOVE_AT: begin
        ok_d      = pos_ok;
        ctl.close = pos_ok;
        rd_en     = pos_ok;
      end
      CMD_READ: begin
        ok_d  = pos_ok;
        rd_en = pos_ok;
      end
      default: ok_d = 1'b0;
    endcase
    if (!in_eval) begin
      ctl = '0;
    end else if (ok_d) begin
      if (cmd_q == CMD_APPEND || cmd_q == CMD_INSERT) begin
        count_d = count_q + CW'(1);
      end else if (cmd_q == CMD_REMOVE_END || cmd_q == CMD_REMOVE_AT) begin
        count_d = count_q - CW'(1);
      end
    end
  end

  // Row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [KEY_W-1:0] lk, rk;
    logic [PAYLOAD_BITS-1:0] lp, rp;

    if (i == 0) begin : g_first
      assign lk = '0;
      assign lp = '0;
    end else begin : g_left
      assign lk = cell_key[i-1];
      assign lp = cell_pay[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rk = '0;
      assign rp = '0;
    end else begin : g_right
      assign rk = cell_key[i+1];
      assign rp = cell_pay[i+1];
    end

    ptl_cell #(
      .IDX_W (IW),
      .CNT_W (CW),
      .IDX   (i),
      .PAY_W (PAYLOAD_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .idx_i       (idx),
      .cnt_i       (count_q),
      .key_i       (key_q),
      .pay_i       (pay_q),
      .left_key_i  (lk),
      .left_pay_i  (lp),
      .right_key_i (rk),
      .right_pay_i (rp),
      .key_o       (cell_key[i]),
      .pay_o       (cell_pay[i]),
      .match_o     (match_w[i])
    );
  end

  // Gather the selected record onto the read bus
  always_comb begin
    rd_key_d = '0;
    rd_pay_d = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (rd_en && (rd_idx == IW'(i))) begin
        rd_key_d = rd_key_d | cell_key[i];
        rd_pay_d = rd_pay_d | cell_pay[i];
      end
    end
  end

  // Capture the evaluation before the cells shift
  always_ff @(posedge clk_i) begin
    if (in_eval) begin
      ok_q     <= ok_d;
      match_q  <= match_w;
      rd_key_q <= rd_key_d;
      rd_pay_q <= rd_pay_d;
    end
  end

  // Encode the first matching slot
  always_comb begin
    hit_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_q[i]) hit_idx = IW'(i);
    end
    any_hit = |match_q;
  end

  // Drive the result
  always_comb begin
    if (cmd_q == CMD_FIND) begin
      ok_o             = any_hit;
      found_position_o = any_hit ? POS_W'({1'b0, hit_idx} + (IW+1)'(1)) : '0;
    end else begin
      ok_o             = ok_q;
      found_position_o = '0;
    end
    out_key_o     = rd_key_q;
    out_payload_o = rd_pay_q;
    entry_count_o = POS_W'(count_q);
  end

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMPW'(count_q) <= CMPW'(CAPACITY))
    else $error("fill count exceeds capacity");

  a_eval_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_eval |=> done_o)
    else $error("evaluation not followed by a result");

  a_append_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ok_o && (cmd_q == CMD_APPEND || cmd_q == CMD_INSERT))
      |-> (count_q == $past(count_q) + CW'(1)))
    else $error("successful add did not grow the list by one");

  a_fail_keeps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !ok_o) |-> (count_q == $past(count_q)))
    else $error("failed command changed the fill count");
`endif

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the positional list table
// Sends append, insert, remove, find and read commands with random gaps,
// tracks the list contents in a local copy, and checks every result field
// against the copy in arrival order.
// ----------------------------------------------------------------------------
module tb
  import ptl_pkg::*;
();

  localparam int CAP = CAPACITY_DEF;
  localparam int PW  = PAYLOAD_BITS_DEF;

  // Command codes the block does not define
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

  localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
  localparam logic [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic             ok;
    logic [POS_W-1:0] found;
    logic [KEY_W-1:0] key;
    logic [PW-1:0]    pay;
    logic [POS_W-1:0] count;
  } list_result_t;

  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    start          = 1'b0;
  logic [CMD_W-1:0]        cmd_i          = '0;
  logic [POS_W-1:0]        position_i     = '0;
  logic signed [KEY_W-1:0] item_key_i     = '0;
  logic [PW-1:0]           item_payload_i = '0;
  logic                    busy;
  logic                    done_o;
  logic                    ok_o;
  logic [POS_W-1:0]        found_position_o;
  logic signed [KEY_W-1:0] out_key_o;
  logic [PW-1:0]           out_payload_o;
  logic [POS_W-1:0]        entry_count_o;

  // Local copy of the list
  logic [KEY_W-1:0] key_mem [CAP];
  logic [PW-1:0]    pay_mem [CAP];
  int               fill_q = 0;

  list_result_t pending_results[$];
  list_result_t head_result;

  int  mismatch_cnt = 0;
  int  item_cnt     = 0;
  int  ok_cnt       = 0;
  int  result_cnt   = 0;
  int  peak_fill    = 0;
  int  full_hits    = 0;
  bit  idle_on      = 1'b1;

  positional_list_table u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .cmd_i            (cmd_i),
    .position_i       (position_i),
    .item_key_i       (item_key_i),
    .item_payload_i   (item_payload_i),
    .done_o           (done_o),
    .ok_o             (ok_o),
    .found_position_o (found_position_o),
    .out_key_o        (out_key_o),
    .out_payload_o    (out_payload_o),
    .entry_count_o    (entry_count_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Apply one command to the local list and return the result it gives
  function automatic list_result_t list_apply(input logic [CMD_W-1:0] op,
                                              input logic [POS_W-1:0] pos,
                                              input logic [KEY_W-1:0] key,
                                              input logic [PW-1:0]    pay);
    list_result_t r;
    int           p;
    int           i;
    r = '0;
    p = pos;
    case (op)
      CMD_APPEND: begin
        if (fill_q < CAP) begin
          key_mem[fill_q] = key;
          pay_mem[fill_q] = pay;
          fill_q++;
          r.ok = 1'b1;
        end
      end
      CMD_INSERT: begin
        if (fill_q < CAP && p >= 1 && p <= fill_q + 1) begin
          for (i = fill_q; i > p - 1; i--) begin
            key_mem[i] = key_mem[i-1];
            pay_mem[i] = pay_mem[i-1];
          end
          key_mem[p-1] = key;
          pay_mem[p-1] = pay;
          fill_q++;
          r.ok = 1'b1;
        end
      end
      CMD_REMOVE_END: begin
        if (fill_q > 0) begin
          fill_q--;
          r.key = key_mem[fill_q];
          r.pay = pay_mem[fill_q];
          r.ok  = 1'b1;
        end
      end
      CMD_REMOVE_AT: begin
        if (p >= 1 && p <= fill_q) begin
          r.key = key_mem[p-1];
          r.pay = pay_mem[p-1];
          for (i = p - 1; i + 1 < fill_q; i++) begin
            key_mem[i] = key_mem[i+1];
            pay_mem[i] = pay_mem[i+1];
          end
          fill_q--;
          r.ok = 1'b1;
        end
      end
      CMD_FIND: begin
        for (i = 0; i < fill_q; i++) begin
          if (!r.ok && key_mem[i] == key) begin
            r.found = POS_W'(i + 1);
            r.ok    = 1'b1;
          end
        end
      end
      CMD_READ: begin
        if (p >= 1 && p <= fill_q) begin
          r.key = key_mem[p-1];
          r.pay = pay_mem[p-1];
          r.ok  = 1'b1;
        end
      end
      default: ;
    endcase
    r.count = POS_W'(fill_q);
    return r;
  endfunction

  // Send one item after a random gap; predict its result on acceptance
  task automatic send_item(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [KEY_W-1:0] key, input logic [PW-1:0] pay);
    int gap;
    if ($urandom_range(0, 39) == 0) idle_on = ~idle_on;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    cmd_i          <= op;
    position_i     <= pos;
    item_key_i     <= key;
    item_payload_i <= pay;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(list_apply(op, pos, key, pay));
    item_cnt++;
    if (fill_q > peak_fill) peak_fill = fill_q;
    if (fill_q == CAP) full_hits++;
  endtask

  // Draw a key: stored keys for hits, a small pool for duplicates, extremes
  function automatic logic [KEY_W-1:0] pick_key(input bit prefer_stored);
    int roll;
    roll = $urandom_range(0, 99);
    if (prefer_stored && fill_q > 0 && roll < 70) return key_mem[$urandom_range(0, fill_q - 1)];
    if (roll < 30) return KEY_W'($urandom_range(0, 7));
    if (roll < 35) return KEY_MIN;
    if (roll < 40) return KEY_MAX;
    if (roll < 45) return '1;
    return $urandom;
  endfunction

  // Issue one random command; add_pct and del_pct steer the list size
  task automatic random_step(input int add_pct, input int del_pct);
    int               roll;
    int               hi;
    logic [CMD_W-1:0] op;
    logic [POS_W-1:0] pos;
    roll = $urandom_range(0, 99);
    if (roll < add_pct) op = $urandom_range(0, 1) ? CMD_APPEND : CMD_INSERT;
    else if (roll < add_pct + del_pct) op = $urandom_range(0, 1) ? CMD_REMOVE_END : CMD_REMOVE_AT;
    else if (roll < 98) op = $urandom_range(0, 1) ? CMD_FIND : CMD_READ;
    else op = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
    // mostly legal positions for the command, sometimes anything in range
    hi = (op == CMD_INSERT) ? fill_q + 1 : fill_q;
    if (hi > CAP) hi = CAP;
    if (hi >= 1 && $urandom_range(0, 99) < 85) pos = POS_W'($urandom_range(1, hi));
    else pos = POS_W'($urandom_range(0, CAP + 1));
    send_item(op, pos, pick_key(op == CMD_FIND), {$urandom, $urandom});
  endtask

  // Check each result against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      result_cnt++;
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("ERROR: result with no command outstanding");
      end else begin
        head_result = pending_results.pop_front();
        if (ok_o !== head_result.ok || found_position_o !== head_result.found ||
            out_key_o !== head_result.key || out_payload_o !== head_result.pay ||
            entry_count_o !== head_result.count) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("ERROR: result %0d expected ok=%0b pos=%0d key=%h pay=%h cnt=%0d",
                     result_cnt, head_result.ok, head_result.found, head_result.key,
                     head_result.pay, head_result.count);
            $display("       got                ok=%0b pos=%0d key=%h pay=%h cnt=%0d",
                     ok_o, found_position_o, out_key_o, out_payload_o, entry_count_o);
          end
        end
        if (head_result.ok) ok_cnt++;
      end
    end
  end

  // Every command but append against an empty list, plus bad positions and spare codes
  task automatic test_empty_list();
    send_item(CMD_FIND, '0, '0, '0);
    send_item(CMD_REMOVE_END, '0, '0, '0);
    send_item(CMD_REMOVE_AT, 7'd1, '0, '0);
    send_item(CMD_READ, 7'd1, '0, '0);
    send_item(CMD_INSERT, 7'd0, KEY_MAX, '1);
    send_item(CMD_INSERT, 7'd2, KEY_MIN, '1);
    send_item(CMD_SPARE_A, 7'd1, '1, '1);
    send_item(CMD_SPARE_B, 7'd65, '1, '1);
  endtask

  // Key and payload extremes, insert at both ends, first-match find, bad positions
  task automatic test_edges();
    send_item(CMD_APPEND, '0, KEY_MIN, '0);
    send_item(CMD_APPEND, '0, KEY_MAX, '1);
    send_item(CMD_INSERT, 7'd1, '1, {32'h5555_5555, 32'h5555_5555});
    send_item(CMD_INSERT, 7'd4, '0, {32'hAAAA_AAAA, 32'hAAAA_AAAA});
    send_item(CMD_INSERT, 7'd3, KEY_MAX, 64'h0123_4567_89AB_CDEF);
    send_item(CMD_FIND, '0, KEY_MAX, '0);
    send_item(CMD_FIND, '0, 32'd12345, '0);
    send_item(CMD_READ, 7'd1, '0, '0);
    send_item(CMD_READ, 7'd5, '0, '0);
    send_item(CMD_READ, 7'd6, '0, '0);
    send_item(CMD_READ, 7'd0, '0, '0);
    send_item(CMD_READ, 7'd64, '0, '0);
    send_item(CMD_REMOVE_AT, 7'd0, '0, '0);
    send_item(CMD_REMOVE_AT, 7'd65, '0, '0);
    send_item(CMD_SPARE_A, 7'd1, KEY_MAX, '1);
    send_item(CMD_REMOVE_AT, 7'd1, '0, '0);
    send_item(CMD_REMOVE_AT, 7'd4, '0, '0);
    send_item(CMD_REMOVE_END, '0, '0, '0);
    send_item(CMD_FIND, '0, KEY_MIN, '0);
  endtask

  // Grow to capacity, then hover there so full-list failures occur
  task automatic test_fill_to_full();
    int n;
    for (n = 0; n < 300 && fill_q < CAP; n++) random_step(80, 5);
    for (n = 0; n < 40; n++) random_step(60, 15);
  endtask

  // Mixed traffic around mid fill
  task automatic test_churn(input int count);
    int n;
    for (n = 0; n < count; n++) random_step(36, 34);
  endtask

  // Shrink to empty, then poke the empty list
  task automatic test_drain();
    int n;
    for (n = 0; n < 300 && fill_q > 0; n++) random_step(5, 75);
    for (n = 0; n < 10; n++) random_step(20, 40);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_edges();
    test_fill_to_full();
    test_churn(150);
    test_drain();
    test_fill_to_full();
    test_drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Ran %0d commands, %0d succeeded, %0d results checked, %0d mismatches",
             item_cnt, ok_cnt, result_cnt, mismatch_cnt);
    $display("List reached %0d of %0d records; %0d commands completed at capacity",
             peak_fill, CAP, full_hits);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("PASS positional_list_table");
    end else begin
      $display("FAIL positional_list_table");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("FAIL positional_list_table");
    $finish;
  end

endmodule
